// File: rtl/segment_intersection_macros.svh
// assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked while out of reset
`define SEGI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("segi check failed");
// checked on every edge, reset included
`define SEGI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("segi check failed");
`else
`define SEGI_ASSERT(lbl, prop)
`define SEGI_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/segi_pkg.sv
// shared types and constants of the segment intersection block
package segi_pkg;

  localparam int OUT_W   = 32;
  localparam int QDEPTH  = 16;
  localparam int DIV_LAT = OUT_W + 2;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_POINT   = 2'd1,
    KIND_OVERLAP = 2'd2,
    KIND_DEGEN   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  ax;
  } ctl_t;

endpackage

// File: rtl/segi_front.sv
// front pipeline: products, exact tests and classification of one segment pair
module segi_front #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_fire,
  input  logic signed [COORD_BITS-1:0]     a_start_x,
  input  logic signed [COORD_BITS-1:0]     a_start_y,
  input  logic signed [COORD_BITS-1:0]     a_end_x,
  input  logic signed [COORD_BITS-1:0]     a_end_y,
  input  logic signed [COORD_BITS-1:0]     b_start_x,
  input  logic signed [COORD_BITS-1:0]     b_start_y,
  input  logic signed [COORD_BITS-1:0]     b_end_x,
  input  logic signed [COORD_BITS-1:0]     b_end_y,
  output logic                             push,
  output segi_pkg::ctl_t                   ctl,
  output logic signed [3*COORD_BITS+2:0]   num0,
  output logic signed [3*COORD_BITS+2:0]   num1,
  output logic [2*COORD_BITS+1:0]          dvs,
  output logic [segi_pkg::OUT_W-1:0]       prim0,
  output logic [segi_pkg::OUT_W-1:0]       prim1
);
  import segi_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int DIFF_W = C + 1;
  localparam int PROD_W = 2 * C + 2;
  localparam int DEN_W  = 2 * C + 3;
  localparam int NUM_W  = 3 * C + 3;
  localparam int DVS_W  = 2 * C + 2;
  localparam int PW     = (C + FRAC_BITS > OUT_W) ? C + FRAC_BITS : OUT_W + 1;

  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  // integer coordinate to saturated fixed point
  function automatic logic [OUT_W-1:0] fix_sat(input logic signed [C-1:0] c);
    logic signed [PW-1:0] w;
    logic [PW-OUT_W:0]    top;
    w   = PW'(c) <<< FRAC_BITS;
    top = w[PW-1:OUT_W-1];
    if (&top || ~|top) return w[OUT_W-1:0];
    return w[PW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  // stage 1: coordinates and differences
  logic v1;
  logic signed [C-1:0]      s1_x1, s1_y1, s1_x2, s1_y2, s1_x3, s1_y3, s1_x4, s1_y4;
  logic signed [DIFF_W-1:0] s1_dxa, s1_dya, s1_dxb, s1_dyb, s1_ex, s1_ey;

  always_ff @(posedge clk) begin
    s1_x1  <= a_start_x;
    s1_y1  <= a_start_y;
    s1_x2  <= a_end_x;
    s1_y2  <= a_end_y;
    s1_x3  <= b_start_x;
    s1_y3  <= b_start_y;
    s1_x4  <= b_end_x;
    s1_y4  <= b_end_y;
    s1_dxa <= DIFF_W'(a_end_x) - DIFF_W'(a_start_x);
    s1_dya <= DIFF_W'(a_end_y) - DIFF_W'(a_start_y);
    s1_dxb <= DIFF_W'(b_end_x) - DIFF_W'(b_start_x);
    s1_dyb <= DIFF_W'(b_end_y) - DIFF_W'(b_start_y);
    s1_ex  <= DIFF_W'(b_start_x) - DIFF_W'(a_start_x);
    s1_ey  <= DIFF_W'(b_start_y) - DIFF_W'(a_start_y);
  end

  // stage 2: cross products, axis choices, overlap clip
  logic c1_ax, c1_uya, c1_uyb;
  logic signed [C-1:0] c1_lo_a, c1_hi_a, c1_lo_b, c1_hi_b;
  logic signed [C-1:0] c1_pa1, c1_pa2, c1_pb1, c1_pb2, c1_o1, c1_olo, c1_ohi;
  logic signed [C-1:0] c1_amin, c1_amax, c1_bmin, c1_bmax, c1_pp, c1_pq;

  always_comb begin
    c1_ax  = mag(s1_dxa) > mag(s1_dya);
    c1_uya = mag(s1_dya) > mag(s1_dxa);
    c1_uyb = mag(s1_dyb) > mag(s1_dxb);
    c1_pp  = c1_uya ? s1_y1 : s1_x1;
    c1_pq  = c1_uya ? s1_y2 : s1_x2;
    c1_lo_a = (c1_pp < c1_pq) ? c1_pp : c1_pq;
    c1_hi_a = (c1_pp < c1_pq) ? c1_pq : c1_pp;
    c1_lo_b = c1_uyb ? ((s1_y3 < s1_y4) ? s1_y3 : s1_y4) : ((s1_x3 < s1_x4) ? s1_x3 : s1_x4);
    c1_hi_b = c1_uyb ? ((s1_y3 < s1_y4) ? s1_y4 : s1_y3) : ((s1_x3 < s1_x4) ? s1_x4 : s1_x3);
    c1_pa1 = c1_ax ? s1_x1 : s1_y1;
    c1_pa2 = c1_ax ? s1_x2 : s1_y2;
    c1_pb1 = c1_ax ? s1_x3 : s1_y3;
    c1_pb2 = c1_ax ? s1_x4 : s1_y4;
    c1_o1  = c1_ax ? s1_y1 : s1_x1;
    c1_amin = (c1_pa1 < c1_pa2) ? c1_pa1 : c1_pa2;
    c1_amax = (c1_pa1 < c1_pa2) ? c1_pa2 : c1_pa1;
    c1_bmin = (c1_pb1 < c1_pb2) ? c1_pb1 : c1_pb2;
    c1_bmax = (c1_pb1 < c1_pb2) ? c1_pb2 : c1_pb1;
    c1_olo = (c1_bmin > c1_amin) ? c1_bmin : c1_amin;
    c1_ohi = (c1_bmax < c1_amax) ? c1_bmax : c1_amax;
  end

  logic v2, s2_degen, s2_ax, s2_uya, s2_uyb;
  logic signed [PROD_W-1:0] s2_pab, s2_pba, s2_pt1, s2_pt2, s2_pc1, s2_pc2;
  logic signed [C-1:0]      s2_x1, s2_y1, s2_lo_a, s2_hi_a, s2_lo_b, s2_hi_b;
  logic signed [C-1:0]      s2_o1, s2_pa1, s2_olo, s2_ohi;
  logic signed [DIFF_W-1:0] s2_dxa, s2_dya, s2_dc, s2_do;

  always_ff @(posedge clk) begin
    s2_pab   <= s1_dxa * s1_dyb;
    s2_pba   <= s1_dya * s1_dxb;
    s2_pt1   <= s1_ex * s1_dyb;
    s2_pt2   <= s1_ey * s1_dxb;
    s2_pc1   <= s1_dxa * s1_ey;
    s2_pc2   <= s1_dya * s1_ex;
    s2_degen <= (s1_dxa == '0 && s1_dya == '0) || (s1_dxb == '0 && s1_dyb == '0);
    s2_ax    <= c1_ax;
    s2_uya   <= c1_uya;
    s2_uyb   <= c1_uyb;
    s2_x1    <= s1_x1;
    s2_y1    <= s1_y1;
    s2_dxa   <= s1_dxa;
    s2_dya   <= s1_dya;
    s2_lo_a  <= c1_lo_a;
    s2_hi_a  <= c1_hi_a;
    s2_lo_b  <= c1_lo_b;
    s2_hi_b  <= c1_hi_b;
    s2_o1    <= c1_o1;
    s2_pa1   <= c1_pa1;
    s2_dc    <= c1_ax ? s1_dxa : s1_dya;
    s2_do    <= c1_ax ? s1_dya : s1_dxa;
    s2_olo   <= c1_olo;
    s2_ohi   <= c1_ohi;
  end

  // stage 3: denominators with den made positive
  logic signed [DEN_W-1:0] c2_den, c2_tn, c2_cross;
  assign c2_den   = DEN_W'(s2_pab) - DEN_W'(s2_pba);
  assign c2_tn    = DEN_W'(s2_pt1) - DEN_W'(s2_pt2);
  assign c2_cross = DEN_W'(s2_pc1) - DEN_W'(s2_pc2);

  logic v3, s3_degen, s3_ax, s3_uya, s3_uyb, s3_par, s3_col, s3_empty;
  logic signed [DEN_W-1:0]  s3_den, s3_tn;
  logic signed [C-1:0]      s3_x1, s3_y1, s3_lo_a, s3_hi_a, s3_lo_b, s3_hi_b;
  logic signed [C-1:0]      s3_o1, s3_pa1, s3_olo, s3_ohi;
  logic signed [DIFF_W-1:0] s3_dxa, s3_dya, s3_dc, s3_do;
  logic [OUT_W-1:0]         s3_prim0, s3_prim1;

  always_ff @(posedge clk) begin
    s3_den   <= c2_den[DEN_W-1] ? -c2_den : c2_den;
    s3_tn    <= c2_den[DEN_W-1] ? -c2_tn : c2_tn;
    s3_par   <= (c2_den == '0);
    s3_col   <= (c2_cross == '0);
    s3_empty <= (s2_olo > s2_ohi);
    s3_prim0 <= fix_sat(s2_olo);
    s3_prim1 <= fix_sat(s2_ohi);
    s3_degen <= s2_degen;
    s3_ax    <= s2_ax;
    s3_uya   <= s2_uya;
    s3_uyb   <= s2_uyb;
    s3_x1    <= s2_x1;
    s3_y1    <= s2_y1;
    s3_dxa   <= s2_dxa;
    s3_dya   <= s2_dya;
    s3_lo_a  <= s2_lo_a;
    s3_hi_a  <= s2_hi_a;
    s3_lo_b  <= s2_lo_b;
    s3_hi_b  <= s2_hi_b;
    s3_o1    <= s2_o1;
    s3_pa1   <= s2_pa1;
    s3_dc    <= s2_dc;
    s3_do    <= s2_do;
    s3_olo   <= s2_olo;
    s3_ohi   <= s2_ohi;
  end

  // stage 4: numerator and bound products
  logic v4, s4_degen, s4_ax, s4_uya, s4_uyb, s4_par, s4_col, s4_empty, s4_dcneg;
  logic signed [NUM_W-1:0] s4_mx, s4_mtx, s4_my, s4_mty;
  logic signed [NUM_W-1:0] s4_bla, s4_bha, s4_blb, s4_bhb, s4_so1, s4_so2, s4_so3;
  logic signed [DEN_W-1:0] s4_den;
  logic [DVS_W-1:0]        s4_dcm;
  logic [OUT_W-1:0]        s4_prim0, s4_prim1;

  always_ff @(posedge clk) begin
    s4_mx    <= s3_x1 * s3_den;
    s4_mtx   <= s3_dxa * s3_tn;
    s4_my    <= s3_y1 * s3_den;
    s4_mty   <= s3_dya * s3_tn;
    s4_bla   <= s3_lo_a * s3_den;
    s4_bha   <= s3_hi_a * s3_den;
    s4_blb   <= s3_lo_b * s3_den;
    s4_bhb   <= s3_hi_b * s3_den;
    s4_so1   <= s3_o1 * s3_dc;
    s4_so2   <= (s3_olo - s3_pa1) * s3_do;
    s4_so3   <= (s3_ohi - s3_pa1) * s3_do;
    s4_den   <= s3_den;
    s4_dcm   <= DVS_W'(mag(s3_dc));
    s4_dcneg <= s3_dc[DIFF_W-1];
    s4_degen <= s3_degen;
    s4_ax    <= s3_ax;
    s4_uya   <= s3_uya;
    s4_uyb   <= s3_uyb;
    s4_par   <= s3_par;
    s4_col   <= s3_col;
    s4_empty <= s3_empty;
    s4_prim0 <= s3_prim0;
    s4_prim1 <= s3_prim1;
  end

  // stage 5: numerator sums
  logic v5, s5_degen, s5_ax, s5_uya, s5_uyb, s5_par, s5_col, s5_empty;
  logic signed [NUM_W-1:0] s5_nx, s5_ny, s5_s0, s5_s1, s5_bla, s5_bha, s5_blb, s5_bhb;
  logic signed [DEN_W-1:0] s5_den;
  logic [DVS_W-1:0]        s5_dcm;
  logic [OUT_W-1:0]        s5_prim0, s5_prim1;
  logic signed [NUM_W-1:0] c4_s0, c4_s1;

  assign c4_s0 = s4_so1 + s4_so2;
  assign c4_s1 = s4_so1 + s4_so3;

  always_ff @(posedge clk) begin
    s5_nx    <= s4_mx + s4_mtx;
    s5_ny    <= s4_my + s4_mty;
    // overlap numerator takes the sign of the primary step
    s5_s0    <= s4_dcneg ? -c4_s0 : c4_s0;
    s5_s1    <= s4_dcneg ? -c4_s1 : c4_s1;
    s5_bla   <= s4_bla;
    s5_bha   <= s4_bha;
    s5_blb   <= s4_blb;
    s5_bhb   <= s4_bhb;
    s5_den   <= s4_den;
    s5_dcm   <= s4_dcm;
    s5_degen <= s4_degen;
    s5_ax    <= s4_ax;
    s5_uya   <= s4_uya;
    s5_uyb   <= s4_uyb;
    s5_par   <= s4_par;
    s5_col   <= s4_col;
    s5_empty <= s4_empty;
    s5_prim0 <= s4_prim0;
    s5_prim1 <= s4_prim1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_fire;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // classification
  logic in_a, in_b;

  always_comb begin
    in_a = s5_uya ? (s5_bla <= s5_ny && s5_ny <= s5_bha) : (s5_bla <= s5_nx && s5_nx <= s5_bha);
    in_b = s5_uyb ? (s5_blb <= s5_ny && s5_ny <= s5_bhb) : (s5_blb <= s5_nx && s5_nx <= s5_bhb);
    ctl.kind = KIND_NONE;
    ctl.ax   = s5_ax;
    num0     = '0;
    num1     = '0;
    dvs      = '0;
    priority if (s5_degen) begin
      ctl.kind = KIND_DEGEN;
    end else if (!s5_par) begin
      if (in_a && in_b) begin
        ctl.kind = KIND_POINT;
        num0     = s5_nx;
        num1     = s5_ny;
        dvs      = DVS_W'(s5_den);
      end
    end else if (s5_col && !s5_empty) begin
      ctl.kind = KIND_OVERLAP;
      num0     = s5_s0;
      num1     = s5_s1;
      dvs      = s5_dcm;
    end else begin
      ctl.kind = KIND_NONE;
    end
  end

  assign push  = v5;
  assign prim0 = s5_prim0;
  assign prim1 = s5_prim1;

endmodule

// File: rtl/segi_queue.sv
// small fifo between the front and the back pipelines
`include "segment_intersection_macros.svh"
module segi_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  import segi_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign dout  = mem[rd_ptr];
  assign empty = (count == '0);

  `SEGI_ASSERT(a_no_overflow, push |-> (count < CNT_W'(DEPTH)))
  `SEGI_ASSERT(a_no_underflow, pop |-> (count != '0))
  `SEGI_ASSERT(a_empty_ptrs, (count == '0) |-> (rd_ptr == wr_ptr))

endmodule

// File: rtl/segi_div.sv
// pipelined fixed point divider lane, one quotient bit per stage, saturating
module segi_div #(
  parameter int NUM_W     = 51,
  parameter int DVS_W     = 34,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [NUM_W-1:0]       num,
  input  logic [DVS_W-1:0]              dvs,
  output logic [segi_pkg::OUT_W-1:0]    quo
);
  import segi_pkg::*;

  localparam int SM_W  = NUM_W + FRAC_BITS;
  localparam int CMP_W = (SM_W > DVS_W) ? SM_W : DVS_W;
  localparam int STEPS = OUT_W;

  logic                  neg_in, sat_in;
  logic [NUM_W-1:0]      mag_in;
  logic [SM_W+OUT_W-1:0] ext_in;
  logic [SM_W-1:0]       hi_in;

  assign neg_in = num[NUM_W-1];
  assign mag_in = neg_in ? NUM_W'(-num) : NUM_W'(num);
  assign ext_in = (SM_W + OUT_W)'(mag_in) << FRAC_BITS;
  assign hi_in  = ext_in[SM_W+OUT_W-1:OUT_W];
  // quotient would need more than the output width
  assign sat_in = CMP_W'(hi_in) >= CMP_W'(dvs);

  logic [DVS_W-1:0] rem  [STEPS+1];
  logic [OUT_W-1:0] bits [STEPS+1];
  logic [OUT_W-1:0] q    [STEPS+1];
  logic [DVS_W-1:0] d    [STEPS+1];
  logic             neg  [STEPS+1];
  logic             sat  [STEPS+1];

  logic [DVS_W:0]   t      [1:STEPS];
  logic             ge     [1:STEPS];
  logic [DVS_W-1:0] rem_nx [1:STEPS];

  always_comb begin
    for (int k = 1; k <= STEPS; k++) begin
      t[k]      = {rem[k-1], bits[k-1][OUT_W-1]};
      ge[k]     = t[k] >= {1'b0, d[k-1]};
      rem_nx[k] = ge[k] ? DVS_W'(t[k] - {1'b0, d[k-1]}) : t[k][DVS_W-1:0];
    end
  end

  logic [OUT_W-1:0] lim, qs, res;

  always_comb begin
    lim = neg[STEPS] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    qs  = (sat[STEPS] || q[STEPS] > lim) ? lim : q[STEPS];
    res = neg[STEPS] ? -qs : qs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DVS_W'(hi_in);
      bits[0] <= ext_in[OUT_W-1:0];
      q[0]    <= '0;
      d[0]    <= dvs;
      neg[0]  <= neg_in;
      sat[0]  <= sat_in;
      for (int k = 1; k <= STEPS; k++) begin
        rem[k]  <= rem_nx[k];
        bits[k] <= {bits[k-1][OUT_W-2:0], 1'b0};
        q[k]    <= {q[k-1][OUT_W-2:0], ge[k]};
        d[k]    <= d[k-1];
        neg[k]  <= neg[k-1];
        sat[k]  <= sat[k-1];
      end
      quo <= res;
    end
  end

endmodule

// File: rtl/segi_back.sv
// back pipeline: two divider lanes, side data and the result register
module segi_back #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             avail,
  output logic                             pop,
  input  segi_pkg::ctl_t                   ctl,
  input  logic signed [3*COORD_BITS+2:0]   num0,
  input  logic signed [3*COORD_BITS+2:0]   num1,
  input  logic [2*COORD_BITS+1:0]          dvs,
  input  logic [segi_pkg::OUT_W-1:0]       prim0,
  input  logic [segi_pkg::OUT_W-1:0]       prim1,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       kind,
  output logic signed [segi_pkg::OUT_W-1:0] first_x,
  output logic signed [segi_pkg::OUT_W-1:0] first_y,
  output logic signed [segi_pkg::OUT_W-1:0] second_x,
  output logic signed [segi_pkg::OUT_W-1:0] second_y
);
  import segi_pkg::*;

  localparam int NUM_W = 3 * COORD_BITS + 3;
  localparam int DVS_W = 2 * COORD_BITS + 2;

  logic             en;
  logic             v      [DIV_LAT];
  ctl_t             sctl   [DIV_LAT];
  logic [OUT_W-1:0] sprim0 [DIV_LAT];
  logic [OUT_W-1:0] sprim1 [DIV_LAT];
  logic [OUT_W-1:0] q0, q1;

  // whole back pipeline holds while a result waits
  assign en        = !out_valid || out_ready;
  assign pop       = en && avail;
  assign out_valid = v[DIV_LAT-1];

  segi_div #(.NUM_W(NUM_W), .DVS_W(DVS_W), .FRAC_BITS(FRAC_BITS)) u_div0 (
    .clk (clk),
    .en  (en),
    .num (num0),
    .dvs (dvs),
    .quo (q0)
  );

  segi_div #(.NUM_W(NUM_W), .DVS_W(DVS_W), .FRAC_BITS(FRAC_BITS)) u_div1 (
    .clk (clk),
    .en  (en),
    .num (num1),
    .dvs (dvs),
    .quo (q1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= pop;
      for (int i = 1; i < DIV_LAT; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sctl[0]   <= ctl;
      sprim0[0] <= prim0;
      sprim1[0] <= prim1;
      for (int i = 1; i < DIV_LAT; i++) begin
        sctl[i]   <= sctl[i-1];
        sprim0[i] <= sprim0[i-1];
        sprim1[i] <= sprim1[i-1];
      end
    end
  end

  ctl_t             oc;
  logic [OUT_W-1:0] p0, p1;

  assign oc   = sctl[DIV_LAT-1];
  assign p0   = sprim0[DIV_LAT-1];
  assign p1   = sprim1[DIV_LAT-1];
  assign kind = oc.kind;

  always_comb begin
    unique case (oc.kind)
      KIND_POINT: begin
        first_x  = q0;
        first_y  = q1;
        second_x = q0;
        second_y = q1;
      end
      KIND_OVERLAP: begin
        first_x  = oc.ax ? p0 : q0;
        first_y  = oc.ax ? q0 : p0;
        second_x = oc.ax ? p1 : q1;
        second_y = oc.ax ? q1 : p1;
      end
      KIND_NONE, KIND_DEGEN: begin
        first_x  = '0;
        first_y  = '0;
        second_x = '0;
        second_y = '0;
      end
      default: begin
        first_x  = '0;
        first_y  = '0;
        second_x = '0;
        second_y = '0;
      end
    endcase
  end

endmodule

// File: rtl/segment_intersection.sv
// throughput: one pair per cycle without stalls, the two divider lanes running in parallel
// the front (5 stages) and queue hold up to 16 pairs; input ready drops when they are all taken
// output stalls freeze the back pipeline only; the front keeps filling the queue
// reset clears valid bits, the queue pointers and the credit count; no clearing pass
module segment_intersection #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COORD_BITS-1:0]     a_start_x,
  input  logic signed [COORD_BITS-1:0]     a_start_y,
  input  logic signed [COORD_BITS-1:0]     a_end_x,
  input  logic signed [COORD_BITS-1:0]     a_end_y,
  input  logic signed [COORD_BITS-1:0]     b_start_x,
  input  logic signed [COORD_BITS-1:0]     b_start_y,
  input  logic signed [COORD_BITS-1:0]     b_end_x,
  input  logic signed [COORD_BITS-1:0]     b_end_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       kind,
  output logic signed [segi_pkg::OUT_W-1:0] first_x,
  output logic signed [segi_pkg::OUT_W-1:0] first_y,
  output logic signed [segi_pkg::OUT_W-1:0] second_x,
  output logic signed [segi_pkg::OUT_W-1:0] second_y
);
  import segi_pkg::*;

  localparam int NUM_W = 3 * COORD_BITS + 3;
  localparam int DVS_W = 2 * COORD_BITS + 2;
  localparam int Q_W   = $bits(ctl_t) + 2 * NUM_W + DVS_W + 2 * OUT_W;
  localparam int CR_W  = $clog2(QDEPTH + 1);

  logic            in_fire, push, pop, q_empty;
  logic [CR_W-1:0] inflight;

  ctl_t                    f_ctl, b_ctl;
  logic signed [NUM_W-1:0] f_num0, f_num1, b_num0, b_num1;
  logic [DVS_W-1:0]        f_dvs, b_dvs;
  logic [OUT_W-1:0]        f_prim0, f_prim1, b_prim0, b_prim1;
  logic [Q_W-1:0]          q_din, q_dout;

  // credits cover every pair in the front and the queue, so neither can overflow
  assign in_ready = (inflight < CR_W'(QDEPTH));
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CR_W'(in_fire) - CR_W'(pop);
    end
  end

  segi_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .a_start_x (a_start_x),
    .a_start_y (a_start_y),
    .a_end_x   (a_end_x),
    .a_end_y   (a_end_y),
    .b_start_x (b_start_x),
    .b_start_y (b_start_y),
    .b_end_x   (b_end_x),
    .b_end_y   (b_end_y),
    .push      (push),
    .ctl       (f_ctl),
    .num0      (f_num0),
    .num1      (f_num1),
    .dvs       (f_dvs),
    .prim0     (f_prim0),
    .prim1     (f_prim1)
  );

  assign q_din = {f_ctl, f_num0, f_num1, f_dvs, f_prim0, f_prim1};

  segi_queue #(.WIDTH(Q_W), .DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .pop   (pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign {b_ctl, b_num0, b_num1, b_dvs, b_prim0, b_prim1} = q_dout;

  segi_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (!q_empty),
    .pop       (pop),
    .ctl       (b_ctl),
    .num0      (b_num0),
    .num1      (b_num1),
    .dvs       (b_dvs),
    .prim0     (b_prim0),
    .prim1     (b_prim1),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .first_x   (first_x),
    .first_y   (first_y),
    .second_x  (second_x),
    .second_y  (second_y)
  );

endmodule
